// File: design/bbts_pkg.sv
// ----------------------------------------------------------------------------
// bbts_pkg
// Shared types and codes for the buzzer beep/tune sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bbts_pkg;

  // Item kind carried on s_axis_tuser.
  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_TICK  = 2'd1,
    FN_LED   = 2'd2
  } func_e;

  // Sequence modes (mode 3 plays like endless).
  localparam logic [1:0] MODE_COUNTED = 2'd0;
  localparam logic [1:0] MODE_ENDLESS = 2'd1;
  localparam logic [1:0] MODE_FOLLOW  = 2'd2;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_INVERT    = 2'd0,
    REG_FREQ_MODE = 2'd1,
    REG_PWM_RANGE = 2'd2
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned DUTY_W     = 9;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned HALF_W     = 17;
  localparam int unsigned OUT_W      = 16;
  localparam logic [CFG_DATA_W-1:0] PWM_RANGE_RST = 10'd1023;

  // One result beat; packed so pin_level lands in the lowest bit.
  typedef struct packed {
    logic              busy_res;
    logic [DUTY_W-1:0] pwm_duty;
    logic              pin_level;
  } bbts_res_t;

endpackage

`default_nettype wire

// File: design/bbts_tune_prep.sv
// ----------------------------------------------------------------------------
// bbts_tune_prep
// Strips leading zeros of a tune and bit-reverses what remains.
// ----------------------------------------------------------------------------
`default_nettype none

module bbts_tune_prep #(
  parameter int unsigned TUNE_BITS = 32
) (
  input  wire logic [TUNE_BITS-1:0]               tune_i,
  output logic      [TUNE_BITS-1:0]               reload_o,
  output logic      [$clog2(TUNE_BITS+1)-1:0]     length_o
);

  localparam int unsigned LW = $clog2(TUNE_BITS + 1);

  logic [TUNE_BITS-1:0] rev;
  logic [LW-1:0]        lz;

  // Leading zeros of the tune are trailing zeros of its reverse.
  always_comb begin
    rev = '0;
    lz  = '0;
    for (int i = 0; i < TUNE_BITS; i++) begin
      rev[i] = tune_i[TUNE_BITS-1-i];
    end
    for (int i = TUNE_BITS - 1; i >= 0; i--) begin
      if (rev[i]) begin
        lz = LW'(i);
      end
    end
  end

  assign reload_o = (tune_i == '0) ? '0 : (rev >> lz);
  assign length_o = (tune_i == '0) ? '0 : (LW'(TUNE_BITS) - lz);

endmodule

`default_nettype wire

// File: design/bbts_out_buf.sv
// ----------------------------------------------------------------------------
// bbts_out_buf
// Two-entry result buffer; ready toward the core is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bbts_out_buf
  import bbts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire bbts_res_t push_data_i,
  output logic           space_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output bbts_res_t      data_o
);

  logic      head_vld_q, head_vld_d;
  logic      tail_vld_q, tail_vld_d;
  bbts_res_t head_q, head_d;
  bbts_res_t tail_q, tail_d;
  logic      pop;

  assign pop = head_vld_q && ready_i;

  always_comb begin
    head_vld_d = head_vld_q;
    tail_vld_d = tail_vld_q;
    head_d     = head_q;
    tail_d     = tail_q;
    if (pop) begin
      if (tail_vld_q) begin
        head_d     = tail_q;
        tail_vld_d = 1'b0;
        if (push_i) begin
          tail_d     = push_data_i;
          tail_vld_d = 1'b1;
        end
      end else begin
        head_vld_d = push_i;
        head_d     = push_data_i;
      end
    end else if (push_i) begin
      if (head_vld_q) begin
        tail_d     = push_data_i;
        tail_vld_d = 1'b1;
      end else begin
        head_d     = push_data_i;
        head_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign space_o = !tail_vld_q;
  assign valid_o = head_vld_q;
  assign data_o  = head_q;

endmodule

`default_nettype wire

// File: design/buzzer_beep_tune_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_beep_tune_sequencer
// A result is registered in the two-entry result buffer and presented on m_axis from there.
// Throughput: one input beat per cycle; s_axis_tready is low only while both
//   entries of the two-deep result buffer are occupied.
// Reset: rst_ni clears all sequencer state and loads register defaults
//   (no inversion, plain level mode, PWM full range 1023).
// ----------------------------------------------------------------------------
`default_nettype none

module buzzer_beep_tune_sequencer
  import bbts_pkg::*;
#(
  parameter int unsigned TUNE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata, low bit up: beep_count[16], on_ticks[16], off_ticks[16],
  //   tune_pattern[TUNE_BITS], beep_mode[2], led_level[1], zero pad
  input  wire logic [((48+TUNE_BITS+3+7)/8)*8-1:0] s_axis_tdata,
  // tuser: func[2]
  input  wire logic [1:0]            s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata, low bit up: pin_level[1], pwm_duty[9], busy_res[1], zero pad
  output logic [OUT_W-1:0]           m_axis_tdata
);

  localparam int unsigned LW      = $clog2(TUNE_BITS + 1);
  localparam int unsigned TUNE_LO = 3 * COUNT_W;
  localparam int unsigned MODE_LO = TUNE_LO + TUNE_BITS;
  localparam int unsigned LED_POS = MODE_LO + 2;

  // ---- input field unpack ----
  logic                 in_acc;
  func_e                in_func;
  logic [COUNT_W-1:0]   in_count, in_on, in_off;
  logic [TUNE_BITS-1:0] in_tune;
  logic [1:0]           in_mode;
  logic                 in_led;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_func  = func_e'(s_axis_tuser);
  assign in_count = s_axis_tdata[COUNT_W-1:0];
  assign in_on    = s_axis_tdata[2*COUNT_W-1:COUNT_W];
  assign in_off   = s_axis_tdata[3*COUNT_W-1:2*COUNT_W];
  assign in_tune  = s_axis_tdata[MODE_LO-1:TUNE_LO];
  assign in_mode  = s_axis_tdata[LED_POS-1:MODE_LO];
  assign in_led   = s_axis_tdata[LED_POS];

  // ---- config registers ----
  logic                  invert_q, freq_mode_q;
  logic [CFG_DATA_W-1:0] pwm_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= 1'b0;
      freq_mode_q <= 1'b0;
      pwm_range_q <= PWM_RANGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_INVERT:    invert_q    <= cfg_data_i[0];
        REG_FREQ_MODE: freq_mode_q <= cfg_data_i[0];
        REG_PWM_RANGE: pwm_range_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- tune preparation (combinational on the start beat) ----
  logic [TUNE_BITS-1:0] prep_reload;
  logic [LW-1:0]        prep_len;

  bbts_tune_prep #(
    .TUNE_BITS (TUNE_BITS)
  ) u_prep (
    .tune_i   (in_tune),
    .reload_o (prep_reload),
    .length_o (prep_len)
  );

  // ---- sequencer state ----
  logic                 en_q, en_d;
  logic [1:0]           mode_q, mode_d;
  logic [HALF_W-1:0]    half_q, half_d;
  logic [COUNT_W-1:0]   left_q, left_d;
  logic [COUNT_W-1:0]   on_q, on_d;
  logic [COUNT_W-1:0]   off_q, off_d;
  logic [TUNE_BITS-1:0] work_q, work_d;
  logic [TUNE_BITS-1:0] reload_q, reload_d;
  logic [LW-1:0]        len_q, len_d;
  logic [LW-1:0]        bits_q, bits_d;
  logic                 level_q, level_d;
  logic                 last_q, last_d;

  logic                 drv;       // this beat drives the pin
  logic                 drv_lvl;   // level before inversion
  logic [HALF_W-1:0]    half_dec;

  assign half_dec = half_q - ((reload_q != '0) ? HALF_W'(2) : HALF_W'(1));

  always_comb begin
    en_d     = en_q;
    mode_d   = mode_q;
    half_d   = half_q;
    left_d   = left_q;
    on_d     = on_q;
    off_d    = off_q;
    work_d   = work_q;
    reload_d = reload_q;
    len_d    = len_q;
    bits_d   = bits_q;
    level_d  = level_q;
    drv      = 1'b0;
    drv_lvl  = 1'b0;
    if (in_acc) begin
      case (in_func)
        FN_START: begin
          off_d    = in_off;
          on_d     = in_on;
          left_d   = COUNT_W'(1);
          mode_d   = in_mode;
          len_d    = prep_len;
          bits_d   = prep_len;
          reload_d = prep_reload;
          work_d   = prep_reload;
          half_d   = {in_count, 1'b0};
          en_d     = (in_count != '0);
          // a zero count stops and drives the pin low before inversion
          drv      = (in_count == '0);
          drv_lvl  = 1'b0;
        end
        FN_TICK: begin
          if (en_q && (mode_q != MODE_FOLLOW)) begin
            if (half_q == '0) begin
              en_d = 1'b0;   // count exhausted, silent
            end else begin
              // zero duration: left stays 0, level is held
              if (left_q != '0) begin
                left_d = left_q - COUNT_W'(1);
                if (left_q == COUNT_W'(1)) begin
                  if (bits_q != '0) begin
                    bits_d  = bits_q - LW'(1);
                    level_d = work_q[0];
                    work_d  = work_q >> 1;
                  end else begin
                    bits_d  = len_q;
                    work_d  = reload_q;
                    level_d = half_dec[0];
                    half_d  = (mode_q != MODE_COUNTED) ? (half_dec | HALF_W'(2)) : half_dec;
                  end
                  left_d = level_d ? on_q : off_q;
                end
              end
              drv     = 1'b1;
              drv_lvl = level_d;
            end
          end
        end
        FN_LED: begin
          if (en_q && (mode_q == MODE_FOLLOW)) begin
            level_d = in_led;
            drv     = 1'b1;
            drv_lvl = in_led;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- pin drive: inversion, PWM duty, change filter in frequency mode ----
  logic      out_lvl;
  logic      push;
  bbts_res_t res;

  assign out_lvl = drv_lvl ^ invert_q;
  assign push    = drv && (!freq_mode_q || (out_lvl != last_q));
  assign last_d  = (drv && freq_mode_q) ? out_lvl : last_q;

  always_comb begin
    res.pin_level = out_lvl;
    res.pwm_duty  = (freq_mode_q && out_lvl) ? pwm_range_q[CFG_DATA_W-1:1] : '0;
    res.busy_res  = en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      mode_q   <= MODE_COUNTED;
      half_q   <= '0;
      left_q   <= '0;
      on_q     <= '0;
      off_q    <= '0;
      work_q   <= '0;
      reload_q <= '0;
      len_q    <= '0;
      bits_q   <= '0;
      level_q  <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      en_q     <= en_d;
      mode_q   <= mode_d;
      half_q   <= half_d;
      left_q   <= left_d;
      on_q     <= on_d;
      off_q    <= off_d;
      work_q   <= work_d;
      reload_q <= reload_d;
      len_q    <= len_d;
      bits_q   <= bits_d;
      level_q  <= level_d;
      last_q   <= last_d;
    end
  end

  // ---- result buffer ----
  bbts_res_t out_res;

  bbts_out_buf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .space_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = OUT_W'(out_res);

  // ---- assertions ----
  // disabled sequencer never holds a pending count
  a_idle_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_q |-> (half_q == '0))
    else $error("sequencer idle with nonzero half-step count");

  // tune cursor never runs past the tune length
  a_bits_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= len_q)
    else $error("tune bits left exceeds tune length");

  // in frequency mode the remembered level tracks the last pushed result
  a_freq_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && freq_mode_q) |=> (last_q == $past(res.pin_level)))
    else $error("last frequency level not updated");

endmodule

`default_nettype wire

// File: verif/tb_buzzer_beep_tune_sequencer.sv
// ----------------------------------------------------------------------------
// tb_buzzer_beep_tune_sequencer
// Self-checking bench for the buzzer beep/tune sequencer. A queue of start,
// tick and LED beats feeds a stream driver. Each accepted beat runs through a
// local model of the sequencer, which queues the pin result it should cause.
// A monitor compares every result beat, field by field, with the oldest
// queued result. The run steps through several register settings, the
// extremes among them. Registers change only while the block is drained.
// ----------------------------------------------------------------------------

module tb_buzzer_beep_tune_sequencer;
  import bbts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TUNE_W    = 32;
  localparam int unsigned TDATA_W   = ((48 + TUNE_W + 3 + 7) / 8) * 8;
  localparam int unsigned STALL_MAX = 1000;  // cycles with no beat moving
  localparam int unsigned PHASE_LEN = 98;    // random beats per setting
  localparam logic [1:0]  FN_UNUSED = 2'd3;  // func code the block ignores

  // One input beat, split into its fields.
  typedef struct {
    logic [1:0]        func;
    logic [15:0]       count;
    logic [15:0]       on_ticks;
    logic [15:0]       off_ticks;
    logic [TUNE_W-1:0] tune;
    logic [1:0]        mode;
    logic              led;
  } beat_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;  // count, on, off, tune, mode, led
  logic [1:0]            s_axis_tuser  = '0;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;        // pin_level, pwm_duty, busy_res

  buzzer_beep_tune_sequencer #(
    .TUNE_BITS(TUNE_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  beat_t       beat_q[$];        // beats waiting for the driver
  beat_t       bus_beat;         // beat currently offered on s_axis
  bbts_res_t   pin_expect_q[$];  // pin results still to come
  int unsigned beats_queued = 0;
  int unsigned fail_count   = 0;
  int unsigned result_idx   = 0;
  int unsigned stall_cycles = 0;
  bit          no_gaps      = 1'b0;  // suspends random idling on both sides

  // Register copies as last written
  logic                  inv_cfg   = 1'b0;
  logic                  freq_cfg  = 1'b0;
  logic [CFG_DATA_W-1:0] range_cfg = PWM_RANGE_RST;

  // Sequencer model state
  logic              sq_on;
  logic [1:0]        sq_mode;
  logic [HALF_W-1:0] half_steps;
  logic [15:0]       ticks_rem;
  logic [15:0]       on_len;
  logic [15:0]       off_len;
  logic [TUNE_W-1:0] tune_shift;
  logic [TUNE_W-1:0] tune_seed;
  logic [5:0]        tune_len;
  logic [5:0]        tune_rem;
  logic              cur_level;
  logic              last_duty_level;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // Pin drive: apply inversion; in frequency mode only a level change counts.
  task automatic drive_level(input logic lvl);
    bbts_res_t r;
    logic      v;
    v = lvl ^ inv_cfg;
    r.pin_level = v;
    r.busy_res  = sq_on;
    r.pwm_duty  = '0;
    if (freq_cfg) begin
      if (v == last_duty_level) return;
      last_duty_level = v;
      if (v) r.pwm_duty = range_cfg[CFG_DATA_W-1:1];
    end
    pin_expect_q.push_back(r);
  endtask

  // Advance the sequencer model by one accepted beat.
  task automatic step_sequencer(input beat_t b);
    int unsigned k;
    case (b.func)
      FN_START: begin
        on_len      = b.on_ticks;
        off_len     = b.off_ticks;
        ticks_rem   = 16'd1;
        sq_mode     = b.mode;
        // tune length = position of the top set bit; play order reversed
        tune_len    = '0;
        tune_seed   = '0;
        for (k = 0; k < TUNE_W; k++) if (b.tune[k]) tune_len = 6'(k + 1);
        for (k = 0; k < tune_len; k++) tune_seed[k] = b.tune[tune_len - 1 - k];
        tune_rem    = tune_len;
        tune_shift  = tune_seed;
        half_steps  = {b.count, 1'b0};
        sq_on       = (half_steps != '0);
        if (!sq_on) drive_level(1'b0);
      end
      FN_TICK: begin
        if (sq_on && sq_mode != MODE_FOLLOW) begin
          if (half_steps == '0) begin
            sq_on = 1'b0;  // count used up: quietly stop
          end else begin
            // a zero duration is never counted down, so the level holds
            if (ticks_rem != '0) begin
              ticks_rem--;
              if (ticks_rem == '0) begin
                if (tune_rem != '0) begin
                  tune_rem--;
                  cur_level  = tune_shift[0];
                  tune_shift = tune_shift >> 1;
                end else begin
                  tune_rem   = tune_len;
                  tune_shift = tune_seed;
                  half_steps = half_steps -
                               ((tune_seed != '0) ? HALF_W'(2) : HALF_W'(1));
                  cur_level  = half_steps[0];
                  if (sq_mode != MODE_COUNTED) half_steps[1] = 1'b1;
                end
                ticks_rem = cur_level ? on_len : off_len;
              end
            end
            drive_level(cur_level);
          end
        end
      end
      FN_LED: begin
        if (sq_on && sq_mode == MODE_FOLLOW) begin
          cur_level = b.led;
          drive_level(cur_level);
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_beat(input logic [1:0] func, input logic [15:0] count,
                            input logic [15:0] on_t, input logic [15:0] off_t,
                            input logic [TUNE_W-1:0] tune, input logic [1:0] mode,
                            input logic led);
    beat_t b;
    b.func      = func;
    b.count     = count;
    b.on_ticks  = on_t;
    b.off_ticks = off_t;
    b.tune      = tune;
    b.mode      = mode;
    b.led       = led;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  // Mostly a start followed by a run of ticks (or LED beats in follow mode),
  // sometimes a single beat of random noise.
  task automatic queue_random_scene();
    logic [15:0]       cnt;
    logic [15:0]       on_d;
    logic [15:0]       off_d;
    logic [TUNE_W-1:0] pat;
    logic [1:0]        md;
    int unsigned       len;
    int unsigned       n;
    int unsigned       k;
    if ($urandom_range(99) < 20) begin
      queue_beat(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom),
                 $urandom, 2'($urandom_range(3)), 1'($urandom_range(1)));
      return;
    end
    cnt   = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(5));
    on_d  = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    off_d = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    md    = 2'($urandom_range(3));
    case ($urandom_range(2))
      0: pat = '0;
      1: pat = $urandom;
      default: begin
        len = $urandom_range(1, 6);
        pat = ($urandom & ((32'd1 << len) - 1)) | (32'd1 << (len - 1));
      end
    endcase
    queue_beat(FN_START, cnt, on_d, off_d, pat, md, 1'($urandom_range(1)));
    n = $urandom_range(4, 30);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 5)
        queue_beat(FN_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                   2'($urandom_range(3)), 1'($urandom_range(1)));
      else if (md == MODE_FOLLOW && $urandom_range(99) < 80)
        queue_beat(FN_LED, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                   2'($urandom_range(3)), 1'($urandom_range(1)));
      else
        queue_beat(FN_TICK, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                   2'($urandom_range(3)), 1'($urandom_range(1)));
    end
  endtask

  // Block until every beat is taken and every result is back, then let the
  // block run on so that beats that produce nothing are finished.
  task automatic wait_drained();
    while (beat_q.size() != 0 || s_axis_tvalid || pin_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Registers are written back to back, one per edge.
  task automatic write_regs(input logic inv, input logic freq,
                            input logic [CFG_DATA_W-1:0] range);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_INVERT;
    cfg_data_i <= CFG_DATA_W'(inv);
    @(posedge clk_i);
    cfg_idx_i  <= REG_FREQ_MODE;
    cfg_data_i <= CFG_DATA_W'(freq);
    @(posedge clk_i);
    cfg_idx_i  <= REG_PWM_RANGE;
    cfg_data_i <= range;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    inv_cfg   = inv;
    freq_cfg  = freq;
    range_cfg = range;
  endtask

  // --------------------------------------------------------------------------
  // Stream driver: offers the next queued beat once the current one is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    beat_t nb;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (beat_q.size() != 0 && (no_gaps || $urandom_range(99) >= 8)) begin
        nb = beat_q.pop_front();
        bus_beat      <= nb;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nb.func;
        s_axis_tdata  <= TDATA_W'({nb.led, nb.mode, nb.tune, nb.off_ticks,
                                   nb.on_ticks, nb.count});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_gaps || ($urandom_range(99) >= 8);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result beats first, then predict from the accepted input
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_proc
    bbts_res_t got;
    bbts_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = bbts_res_t'(m_axis_tdata[$bits(bbts_res_t)-1:0]);
        if (pin_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", result_idx));
        end else begin
          want = pin_expect_q.pop_front();
          if (got.pin_level !== want.pin_level)
            report_mismatch($sformatf("result %0d pin_level %b, want %b",
                                      result_idx, got.pin_level, want.pin_level));
          if (got.pwm_duty !== want.pwm_duty)
            report_mismatch($sformatf("result %0d pwm_duty %0d, want %0d",
                                      result_idx, got.pwm_duty, want.pwm_duty));
          if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("result %0d busy_res %b, want %b",
                                      result_idx, got.busy_res, want.busy_res));
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready) step_sequencer(bus_beat);
    end
  end

  // Watchdog: only counts while work is outstanding
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (beat_q.size() == 0 && !s_axis_tvalid && pin_expect_q.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : main_proc
    int unsigned phase;
    int unsigned target;
    logic        inv_p;
    logic        freq_p;
    logic [9:0]  range_p;

    sq_on = 1'b0;  sq_mode = '0;     half_steps = '0; ticks_rem = '0;
    on_len = '0;   off_len = '0;     tune_shift = '0; tune_seed = '0;
    tune_len = '0; tune_rem = '0;    cur_level = 1'b0;
    last_duty_level = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored beats, stop, count running out, extremes,
    // zero durations and LED following.
    queue_beat(FN_UNUSED, '1, '1, '1, '1, 2'd3, 1'b1);
    queue_beat(FN_TICK, '0, '0, '0, '0, MODE_COUNTED, 1'b0);
    queue_beat(FN_LED, '0, '0, '0, '0, MODE_FOLLOW, 1'b1);
    queue_beat(FN_START, '0, '0, '0, '0, MODE_COUNTED, 1'b0);
    queue_beat(FN_START, 16'd1, 16'd1, 16'd1, '0, MODE_COUNTED, 1'b0);
    repeat (5) queue_beat(FN_TICK, '0, '0, '0, '0, MODE_COUNTED, 1'b0);
    queue_beat(FN_START, '1, '1, '0, '1, 2'd3, 1'b0);
    repeat (3) queue_beat(FN_TICK, '1, '1, '1, '1, 2'd3, 1'b1);
    queue_beat(FN_START, 16'd2, '0, '0, 32'h8000_0000, MODE_COUNTED, 1'b0);
    repeat (3) queue_beat(FN_TICK, '0, '0, '0, '0, MODE_COUNTED, 1'b0);
    queue_beat(FN_START, 16'd1, 16'd2, 16'd2, 32'h5, MODE_FOLLOW, 1'b0);
    queue_beat(FN_LED, '0, '0, '0, '0, MODE_COUNTED, 1'b1);
    queue_beat(FN_LED, '0, '0, '0, '0, MODE_COUNTED, 1'b0);
    queue_beat(FN_TICK, '0, '0, '0, '0, MODE_COUNTED, 1'b0);
    queue_beat(FN_LED, '1, '1, '1, '1, 2'd3, 1'b1);

    // Settings: defaults, inversion, freq mode at full / unit / zero / 682 range,
    // then random ones. The no-gap stretch sits on one phase.
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin inv_p = 1'b0; freq_p = 1'b0; range_p = PWM_RANGE_RST; end
        1: begin inv_p = 1'b1; freq_p = 1'b0; range_p = 10'd1023; end
        2: begin inv_p = 1'b0; freq_p = 1'b1; range_p = 10'd1023; end
        3: begin inv_p = 1'b1; freq_p = 1'b1; range_p = 10'd1;    end
        4: begin inv_p = 1'b0; freq_p = 1'b1; range_p = 10'd0;    end
        5: begin inv_p = 1'b1; freq_p = 1'b1; range_p = 10'd682;  end
        6: begin inv_p = 1'b0; freq_p = 1'b0; range_p = 10'($urandom); end
        default: begin
          inv_p = 1'($urandom_range(1)); freq_p = 1'($urandom_range(1));
          range_p = 10'($urandom);
        end
      endcase
      if (phase != 0) begin
        wait_drained();
        write_regs(inv_p, freq_p, range_p);
      end
      no_gaps = (phase == 3);
      target = beats_queued + PHASE_LEN;
      while (beats_queued < target) queue_random_scene();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pin_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pin_expect_q.size()));

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/bbts_pkg.sv
design/bbts_tune_prep.sv
design/bbts_out_buf.sv
design/buzzer_beep_tune_sequencer.sv
verif/tb_buzzer_beep_tune_sequencer.sv
